// ===== design/tcmc_pkg.sv =====
// Shared types, constants and helpers of the tick clock median calibrator.
package tcmc_pkg;

  localparam int unsigned SamplesDef  = 10;
  localparam int unsigned FracBitsDef = 32;

  typedef enum logic [1:0] {
    ModeSample = 2'd0,
    ModeTick2T = 2'd1,
    ModeT2Tick = 2'd2,
    ModeNone   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StStored = 2'd0,
    StCalDone = 2'd1,
    StConv   = 2'd2,
    StZeroDiv = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] tick_start;
    logic [63:0] tick_end;
    logic [62:0] time_start;
    logic [62:0] time_end;
    logic [63:0] query;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] converted;
    logic [63:0] ratio;
    logic [62:0] ref_time_out;
    logic [63:0] ref_tick_out;
  } out_t;

  // Magnitude of a two's complement 64-bit value.
  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

// ===== design/tcmc_ram.sv =====
// Generic single-port-write, registered-read RAM.
module tcmc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tcmc_div.sv =====
// Restoring divider, one quotient bit per cycle, low 64 quotient bits kept.
module tcmc_div #(
  parameter int unsigned NumW = 96
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [63:0]     den_i,
  output logic            done_o,
  output logic [63:0]     quot_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [63:0]     den_q, den_d;
  logic [63:0]     rem_q, rem_d;
  logic [63:0]     quot_q, quot_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [64:0]     rem_s;
  logic            ge;

  // One shift-compare-subtract step
  always_comb begin
    rem_s  = {rem_q, num_q[NumW-1]};
    ge     = rem_s >= {1'b0, den_q};
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quot_d = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d  = {num_q[NumW-2:0], 1'b0};
      rem_d  = ge ? 64'(rem_s - {1'b0, den_q}) : rem_s[63:0];
      quot_d = {quot_q[62:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== design/tcmc_mul.sv =====
// 64x64 multiplier built from four 32x32 partial products.
module tcmc_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   a_i,
  input  logic [63:0]   b_i,
  output logic          done_o,
  output logic [127:0]  prod_o
);

  logic [63:0]  a_q, b_q;
  logic [2:0]   step_q;
  logic         busy_q, ppv_q, done_q;
  logic [63:0]  pp_q;
  logic [1:0]   sh_q;
  logic [127:0] acc_q;
  logic [31:0]  ah, bh;
  logic [127:0] pp_shift;

  // Pick the halves for this step
  assign ah = step_q[0] ? a_q[63:32] : a_q[31:0];
  assign bh = step_q[1] ? b_q[63:32] : b_q[31:0];

  // Align the registered partial product
  always_comb begin
    case (sh_q)
      2'd0:    pp_shift = {64'd0, pp_q};
      2'd1:    pp_shift = {32'd0, pp_q, 32'd0};
      default: pp_shift = {pp_q, 64'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ppv_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ppv_q  <= 1'b0;
        step_q <= '0;
      end else if (busy_q) begin
        ppv_q  <= !step_q[2];
        step_q <= step_q + 1'b1;
        if (step_q[2]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Multiply one pair of halves, accumulate the previous one
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      pp_q <= ah * bh;
      sh_q <= 2'({1'b0, step_q[0]} + {1'b0, step_q[1]});
      if (ppv_q) begin
        acc_q <= acc_q + pp_shift;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== design/tick_clock_median_calibrator_top.sv =====
// Top level of the tick clock median calibrator.
//
// Usage: items enter on in_valid_i/in_ready_o and results leave on
// out_valid_o/out_ready_i, one result per item, both as packed structs.
// A sample item (mode 0) stores one ratio and both midpoints; every SAMPLES
// samples the median by ratio is latched as the new calibration. Mode 1
// converts a tick to ns, mode 2 ns to a tick, against that calibration.
// One item is worked at a time; in_ready_o is high only while idle.
// A sample needs one 64+FRAC_BITS step division in the shared restoring
// divider, or none when its ratio saturates or clamps; the sample closing a
// round adds a rank scan of every stored sample per candidate, up to SAMPLES
// candidates, paced by the single read port of the sample RAM. Tick to ns
// uses the multiplier, ns to tick the divider; mode 3 and an uncalibrated
// ns to tick go straight to the output.
// Reset clears the sample count and the calibration to zero; the sample RAM
// is not cleared, as each round writes every entry before it is read.
// A stalled receiver holds the result in the output register; a finished
// item then waits until that register is free.
module tick_clock_median_calibrator_top #(
  parameter int unsigned SAMPLES   = tcmc_pkg::SamplesDef,
  parameter int unsigned FRAC_BITS = tcmc_pkg::FracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tcmc_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tcmc_pkg::out_t out_data_o
);
  import tcmc_pkg::*;

  localparam int unsigned IdxW  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned CntW  = $clog2(SAMPLES + 1);
  localparam int unsigned NumW  = 64 + FRAC_BITS;
  localparam int unsigned RamW  = 64 + 63 + 64;
  localparam int unsigned Half  = SAMPLES / 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_SDIV  = 4'd2;
  localparam logic [3:0] S_SWR   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_CDIV  = 4'd5;
  localparam logic [3:0] S_MRI   = 4'd6;
  localparam logic [3:0] S_MCAP  = 4'd7;
  localparam logic [3:0] S_MCMP  = 4'd8;
  localparam logic [3:0] S_MCHK  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]      state_q, state_d;
  in_t             in_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [63:0]     cal_ratio_q, cal_ratio_d;
  logic [62:0]     cal_time_q, cal_time_d;
  logic [63:0]     cal_tick_q, cal_tick_d;
  logic [1:0]      status_q, status_d;
  logic [63:0]     conv_q, conv_d;
  logic [63:0]     sratio_q, sratio_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d;
  logic [CntW-1:0] rank_q, rank_d;
  logic [RamW-1:0] cand_q, cand_d;
  logic            out_valid_q;
  out_t            out_q;

  // Sample and query arithmetic on the held item
  logic [63:0] dt, dn, mt, mn, hi, dq, mq, mid_time, mid_tick;
  logic        nt, nn, nq;
  assign dt = in_q.tick_end - in_q.tick_start;
  assign dn = {1'b0, in_q.time_end} - {1'b0, in_q.time_start};
  assign nt = dt[63];
  assign nn = dn[63];
  assign mt = mag64(dt);
  assign mn = mag64(dn);
  assign hi = mn >> (64 - FRAC_BITS);
  assign mid_time = {1'b0, in_q.time_start} + (nn ? (64'd0 - (mn >> 1)) : (mn >> 1));
  assign mid_tick = in_q.tick_start + (nt ? (64'd0 - (mt >> 1)) : (mt >> 1));
  assign dq = (in_q.mode == ModeTick2T) ? (in_q.query - cal_tick_q)
                                        : (in_q.query - {1'b0, cal_time_q});
  assign nq = dq[63];
  assign mq = mag64(dq);

  // Divider shared by samples and ns to tick, multiplier for tick to ns
  logic            div_start, div_done, mul_start, mul_done;
  logic [63:0]     div_quot;
  logic [127:0]    mul_prod;
  logic [63:0]     div_mag, div_den, mul_res;
  logic [NumW-1:0] div_num;

  assign div_mag = (in_q.mode == ModeSample) ? mn : mq;
  assign div_den = (in_q.mode == ModeSample) ? mt : cal_ratio_q;
  assign div_num = {div_mag, {FRAC_BITS{1'b0}}};
  assign mul_res = mul_prod[FRAC_BITS +: 64];

  tcmc_div #(.NumW(NumW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot)
  );

  tcmc_mul u_mul (
    .clk_i, .rst_ni,
    .start_i(mul_start), .a_i(mq), .b_i(cal_ratio_q),
    .done_o(mul_done), .prod_o(mul_prod)
  );

  // Sample store: ratio, mid time, mid tick
  logic            ram_we;
  logic [IdxW-1:0] ram_raddr;
  logic [RamW-1:0] ram_rdata;
  logic [63:0]     rd_ratio, cand_ratio;

  tcmc_ram #(.Width(RamW), .Depth(SAMPLES), .AddrW(IdxW)) u_ram (
    .clk_i,
    .we_i(ram_we), .waddr_i(cnt_q[IdxW-1:0]),
    .wdata_i({sratio_q, mid_time[62:0], mid_tick}),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  assign rd_ratio   = ram_rdata[RamW-1 -: 64];
  assign cand_ratio = cand_q[RamW-1 -: 64];

  logic hit;
  assign hit = (rd_ratio < cand_ratio) || ((rd_ratio == cand_ratio) && (j_q < i_q));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cal_ratio_d = cal_ratio_q;
    cal_time_d  = cal_time_q;
    cal_tick_d  = cal_tick_q;
    status_d    = status_q;
    conv_d      = conv_q;
    sratio_d    = sratio_q;
    i_d         = i_q;
    j_d         = j_q;
    rank_d      = rank_q;
    cand_d      = cand_q;
    div_start   = 1'b0;
    mul_start   = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = i_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        conv_d = '0;
        case (in_q.mode)
          ModeSample: begin
            status_d = StStored;
            if (mt == '0) begin
              sratio_d = '1;
              status_d = StZeroDiv;
              state_d  = S_SWR;
            end else if ((mn == '0) || (nt != nn)) begin
              sratio_d = '0;
              state_d  = S_SWR;
            end else if (hi >= mt) begin
              sratio_d = '1;
              state_d  = S_SWR;
            end else begin
              div_start = 1'b1;
              state_d   = S_SDIV;
            end
          end
          ModeTick2T: begin
            status_d  = StConv;
            mul_start = 1'b1;
            state_d   = S_MUL;
          end
          ModeT2Tick: begin
            if (cal_ratio_q == '0) begin
              status_d = StZeroDiv;
              conv_d   = '1;
              state_d  = S_OUT;
            end else begin
              status_d  = StConv;
              div_start = 1'b1;
              state_d   = S_CDIV;
            end
          end
          default: begin
            status_d = StConv;
            state_d  = S_OUT;
          end
        endcase
      end
      S_SDIV: begin
        if (div_done) begin
          sratio_d = div_quot;
          state_d  = S_SWR;
        end
      end
      S_SWR: begin
        ram_we = 1'b1;
        if (cnt_q + 1'b1 >= CntW'(SAMPLES)) begin
          cnt_d    = '0;
          status_d = StCalDone;
          i_d      = '0;
          state_d  = S_MRI;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_OUT;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          conv_d  = {1'b0, cal_time_q} + (nq ? (64'd0 - mul_res) : mul_res);
          state_d = S_OUT;
        end
      end
      S_CDIV: begin
        if (div_done) begin
          conv_d  = cal_tick_q + (nq ? (64'd0 - div_quot) : div_quot);
          state_d = S_OUT;
        end
      end
      S_MRI: begin
        ram_raddr = i_q;
        state_d   = S_MCAP;
      end
      S_MCAP: begin
        cand_d    = ram_rdata;
        rank_d    = '0;
        j_d       = '0;
        ram_raddr = '0;
        state_d   = S_MCMP;
      end
      S_MCMP: begin
        ram_raddr = IdxW'(j_q + 1'b1);
        if (hit) begin
          rank_d = rank_q + 1'b1;
        end
        if (j_q == IdxW'(SAMPLES - 1)) begin
          state_d = S_MCHK;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_MCHK: begin
        if (rank_q == CntW'(Half)) begin
          cal_ratio_d = cand_q[RamW-1 -: 64];
          cal_time_d  = cand_q[126:64];
          cal_tick_d  = cand_q[63:0];
          state_d     = S_OUT;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_MRI;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  logic out_load;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cal_ratio_q <= '0;
      cal_time_q  <= '0;
      cal_tick_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cal_ratio_q <= cal_ratio_d;
      cal_time_q  <= cal_time_d;
      cal_tick_q  <= cal_tick_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the item and the working values
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    status_q <= status_d;
    conv_q   <= conv_d;
    sratio_q <= sratio_d;
    i_q      <= i_d;
    j_q      <= j_d;
    rank_q   <= rank_d;
    cand_q   <= cand_d;
    if (out_load) begin
      out_q.status       <= status_q;
      out_q.converted    <= conv_q;
      out_q.ratio        <= cal_ratio_q;
      out_q.ref_time_out <= cal_time_q;
      out_q.ref_tick_out <= cal_tick_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of the tick clock median calibrator top level.
module tb_top;
  import tcmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSamp = SamplesDef;
  localparam int unsigned NFrac = FracBitsDef;
  localparam int unsigned NRand = 1150;
  localparam longint unsigned CycleLimit = 2000000;
  localparam logic [63:0] AllOnes = '1;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  in_t pending_items[$];
  out_t expected_results[$];
  int unsigned fail_count;
  longint unsigned cycle_count;
  bit quiet_tail;
  bit hold_sender;
  bit in_accepted;
  int unsigned send_gap;
  int unsigned recv_gap;

  // Calibration state of the predictor
  logic [63:0] cal_ratio_q;
  logic [62:0] cal_time_q;
  logic [63:0] cal_tick_q;
  logic [63:0] round_ratio[NSamp];
  logic [62:0] round_mid_time[NSamp];
  logic [63:0] round_mid_tick[NSamp];
  int unsigned round_fill;

  tick_clock_median_calibrator_top i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  // Offset a start point by half the signed delta, truncating toward zero
  function automatic logic [63:0] midpoint(input logic [63:0] start, input logic [63:0] delta);
    logic [63:0] h;
    h = abs64(delta) >> 1;
    return delta[63] ? start - h : start + h;
  endfunction

  // Predict the result of one item and advance the calibration
  function automatic out_t predict_calibration(input in_t it);
    out_t res;
    logic [63:0] dt, dn, mt, mn, r, m, p;
    logic [127:0] wide;
    int unsigned rank;
    res = '0;
    res.status = StConv;
    case (mode_e'(it.mode))
      ModeSample: begin
        dt = it.tick_end - it.tick_start;
        dn = {1'b0, it.time_end} - {1'b0, it.time_start};
        mt = abs64(dt);
        mn = abs64(dn);
        res.status = StStored;
        if (mt == 0) begin
          r = AllOnes;
          res.status = StZeroDiv;
        end else if (mn == 0 || dt[63] != dn[63]) begin
          r = '0;
        end else begin
          wide = ({64'd0, mn} << NFrac) / {64'd0, mt};
          r = (wide[127:64] != 0) ? AllOnes : wide[63:0];
        end
        round_ratio[round_fill] = r;
        round_mid_time[round_fill] = 63'(midpoint({1'b0, it.time_start}, dn));
        round_mid_tick[round_fill] = midpoint(it.tick_start, dt);
        round_fill++;
        if (round_fill >= NSamp) begin
          for (int i = 0; i < NSamp; i++) begin
            rank = 0;
            for (int j = 0; j < NSamp; j++)
              if (round_ratio[j] < round_ratio[i] ||
                  (round_ratio[j] == round_ratio[i] && j < i)) rank++;
            if (rank == NSamp / 2) begin
              cal_ratio_q = round_ratio[i];
              cal_time_q = round_mid_time[i];
              cal_tick_q = round_mid_tick[i];
            end
          end
          round_fill = 0;
          res.status = StCalDone;
        end
      end
      ModeTick2T: begin
        m = abs64(it.query - cal_tick_q);
        wide = {64'd0, m} * {64'd0, cal_ratio_q};
        p = wide[NFrac +: 64];
        res.converted = (it.query - cal_tick_q) >= 64'h8000_0000_0000_0000
          ? {1'b0, cal_time_q} - p : {1'b0, cal_time_q} + p;
      end
      ModeT2Tick: begin
        if (cal_ratio_q == 0) begin
          res.status = StZeroDiv;
          res.converted = AllOnes;
        end else begin
          dn = it.query - {1'b0, cal_time_q};
          m = abs64(dn);
          wide = ({64'd0, m} << NFrac) / {64'd0, cal_ratio_q};
          p = wide[63:0];
          res.converted = dn[63] ? cal_tick_q - p : cal_tick_q + p;
        end
      end
      default: ;
    endcase
    res.ratio = cal_ratio_q;
    res.ref_time_out = cal_time_q;
    res.ref_tick_out = cal_tick_q;
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] cal_tick_probe();
    return rand64() >> $urandom_range(0, 63);
  endfunction

  // Random item: samples, mostly plausible with some extremes, conversions and mode 3
  function automatic in_t random_item();
    in_t it;
    logic [63:0] span;
    it.tick_start = rand64();
    it.time_start = 63'(rand64());
    it.query = rand64();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        it.mode = ModeSample;
        span = 64'($urandom_range(1, 1 << 20));
        it.tick_end = it.tick_start + span;
        it.time_end = 63'({1'b0, it.time_start} + span * $urandom_range(1, 3) +
          $urandom_range(0, 4000) - 2000);
        if ($urandom_range(0, 9) == 0) it.tick_end = rand64();
        if ($urandom_range(0, 19) == 0) it.tick_end = it.tick_start;
        if ($urandom_range(0, 19) == 0) it.time_end = it.time_start;
      end
      5, 6: begin
        it.mode = ModeTick2T;
        it.tick_end = rand64();
        it.time_end = 63'(rand64());
        if ($urandom_range(0, 1)) it.query = cal_tick_probe() + $urandom_range(0, 1 << 24);
      end
      7, 8: begin
        it.mode = ModeT2Tick;
        it.tick_end = rand64();
        it.time_end = 63'(rand64());
        if ($urandom_range(0, 1)) it.query = rand64() >> $urandom_range(1, 40);
      end
      default: begin
        it.mode = ModeNone;
        it.tick_end = rand64();
        it.time_end = 63'(rand64());
      end
    endcase
    return it;
  endfunction

  function automatic in_t sample_item(input logic [63:0] t0, input logic [63:0] t1,
                                      input logic [62:0] n0, input logic [62:0] n1);
    in_t it;
    it = '0;
    it.mode = ModeSample;
    it.tick_start = t0;
    it.tick_end = t1;
    it.time_start = n0;
    it.time_end = n1;
    it.query = rand64();
    return it;
  endfunction

  function automatic in_t query_item(input mode_e md, input logic [63:0] q);
    in_t it;
    it = random_item();
    it.mode = md;
    it.query = q;
    return it;
  endfunction

  // Driver: present the oldest pending item, idle in bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_accepted) begin
        // hold the item until accepted
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0 && !hold_sender) begin
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 12);
          in_valid_i <= 1'b0;
        end else begin
          in_data_i <= pending_items[0];
          in_valid_i <= 1'b1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Predict at acceptance so the expectation order follows the block
  always @(posedge clk_i) begin
    in_accepted <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_results.push_back(predict_calibration(in_data_i));
      void'(pending_items.pop_front());
    end
  end

  // Receiver stalls in bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 12);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    out_t want;
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          fail_count++;
        end
        if (out_data_o.converted !== want.converted) begin
          $error("converted: expected %h, got %h", want.converted, out_data_o.converted);
          fail_count++;
        end
        if (out_data_o.ratio !== want.ratio) begin
          $error("ratio: expected %h, got %h", want.ratio, out_data_o.ratio);
          fail_count++;
        end
        if (out_data_o.ref_time_out !== want.ref_time_out) begin
          $error("ref_time_out: expected %h, got %h", want.ref_time_out,
                 out_data_o.ref_time_out);
          fail_count++;
        end
        if (out_data_o.ref_tick_out !== want.ref_tick_out) begin
          $error("ref_tick_out: expected %h, got %h", want.ref_tick_out,
                 out_data_o.ref_tick_out);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (cycle_count >= CycleLimit) begin
      $display("tick_clock_median_calibrator_top regression: fail");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    rst_ni = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    quiet_tail = 1'b0;
    hold_sender = 1'b0;
    in_accepted = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    cal_ratio_q = '0;
    cal_time_q = '0;
    cal_tick_q = '0;
    round_fill = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: conversions before calibration, mode 3, a round of extreme samples, then conversions against it
    pending_items.push_back(query_item(ModeT2Tick, AllOnes));
    pending_items.push_back(query_item(ModeTick2T, AllOnes));
    pending_items.push_back(query_item(ModeNone, 64'd0));
    pending_items.push_back(sample_item(64'd0, AllOnes, 63'd0, '1));
    pending_items.push_back(sample_item(AllOnes, 64'd0, '1, 63'd0));
    pending_items.push_back(sample_item(64'd5, 64'd5, 63'd1, 63'd9));
    pending_items.push_back(sample_item(64'd100, 64'd50, 63'd10, 63'd90));
    pending_items.push_back(sample_item(64'd0, 64'd1, 63'd0, '1));
    pending_items.push_back(sample_item(64'd7, 64'd17, 63'd3, 63'd3));
    pending_items.push_back(sample_item(64'd1000, 64'd2000, 63'd500, 63'd2500));
    pending_items.push_back(sample_item(64'd1000, 64'd2000, 63'd500, 63'd2500));
    pending_items.push_back(sample_item(64'd2000, 64'd1000, 63'd2500, 63'd500));
    pending_items.push_back(sample_item(64'd40, 64'd80, 63'd40, 63'd120));
    pending_items.push_back(query_item(ModeTick2T, 64'd0));
    pending_items.push_back(query_item(ModeTick2T, AllOnes));
    pending_items.push_back(query_item(ModeT2Tick, 64'd0));
    pending_items.push_back(query_item(ModeT2Tick, AllOnes));
    pending_items.push_back(query_item(ModeNone, AllOnes));

    // Let everything drain once before random traffic
    hold_sender = 1'b0;
    wait (pending_items.size() == 0);
    hold_sender = 1'b1;
    wait (expected_results.size() == 0);
    @(negedge clk_i);
    hold_sender = 1'b0;

    for (int n = 0; n < NRand; n++) begin
      if (n == NRand - 150) begin
        wait (pending_items.size() == 0);
        quiet_tail = 1'b1;
      end
      pending_items.push_back(random_item());
      if (pending_items.size() > 8) wait (pending_items.size() <= 4);
    end
    wait (pending_items.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tick_clock_median_calibrator_top regression: pass");
    end else begin
      $display("tick_clock_median_calibrator_top regression: fail");
    end
    $finish;
  end

endmodule
